@@ rtl/mbsrc_pkg.sv @@
// Shared constants for the Modbus reply checker.
`default_nettype none
package mbsrc_pkg;

  // Frame geometry
  localparam int FRAME_BYTES = 21;
  localparam int CNT_W       = 5;

  // Protocol constants
  localparam logic [15:0] CRC_INIT          = 16'hFFFF;
  localparam logic [15:0] CRC_POLY          = 16'hA001;
  localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;

  // Outcome codes
  localparam logic [2:0] CAUSE_OK       = 3'd0;
  localparam logic [2:0] CAUSE_TIMEOUT  = 3'd1;
  localparam logic [2:0] CAUSE_ADDRESS  = 3'd2;
  localparam logic [2:0] CAUSE_FUNCTION = 3'd3;
  localparam logic [2:0] CAUSE_CRC      = 3'd4;

  // Result payload width, padded to whole bytes
  localparam int RES_BITS  = 1 + 3 + 1 + 3 * 32;
  localparam int RES_BYTES = (RES_BITS + 7) / 8;
  localparam int OUT_W     = RES_BYTES * 8;

endpackage : mbsrc_pkg
`default_nettype wire

@@ rtl/mbsrc_crc_step.sv @@
// Reflected CRC-16 update over one byte, eight bit steps unrolled.
`default_nettype none
module mbsrc_crc_step (
  input  wire logic [15:0] crc_in,
  input  wire logic [7:0]  data_in,
  output logic      [15:0] crc_out
);
  import mbsrc_pkg::*;

  // Fold the byte in, then shift out eight bits
  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {8'h00, data_in};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule : mbsrc_crc_step
`default_nettype wire

@@ rtl/modbus_status_reply_checker.sv @@
// Top level: Modbus RTU read-holding reply checker with stream ports.
// Stage one holds an accepted item and does its CRC update as one unrolled byte step;
//   when it fires, the frame state updates and a result is registered to out_tvalid.
// Throughput: one item per cycle unless a result finds the output full and stalls.
// A frame of FRAME_BYTES bytes gives one result; a timeout item gives one at once.
// Reset (rst_n low, synchronous): pipeline empty, counter and flags cleared, CRC at
//   0xFFFF, held values zero, offline, slave address 1.
`default_nettype none
module modbus_status_reply_checker (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // configuration
  input  wire logic                        cfg_we,
  input  wire logic [7:0]                  cfg_wdata,     // slave_address
  // input items
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [7:0]                  in_tdata,      // [7:0] byte_in
  input  wire logic                        in_tuser,      // [0] op
  // result items
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  // [0] frame_ok, [3:1] fail_cause, [4] link_online, [36:5] device_status,
  // [68:37] position_mm, [100:69] speed_mm_s, [103:101] zero
  output logic [mbsrc_pkg::OUT_W-1:0]      out_tdata
);
  import mbsrc_pkg::*;

  localparam logic [CNT_W-1:0] POS_LAST    = CNT_W'(FRAME_BYTES - 1);
  localparam logic [CNT_W-1:0] POS_CRC_LO  = CNT_W'(FRAME_BYTES - 2);
  localparam logic [CNT_W-1:0] POS_WORD_LO = CNT_W'(3);
  localparam logic [CNT_W-1:0] POS_WORD_HI = CNT_W'(14);

  // Registers
  logic             s1_valid_r;
  logic             s1_op_r;
  logic [7:0]       s1_byte_r;
  logic [7:0]       slave_addr_r;
  logic [CNT_W-1:0] byte_cnt_r,  byte_cnt_nxt;
  logic [15:0]      crc_r,       crc_nxt;
  logic [1:0]       hdr_r,       hdr_nxt;
  logic [7:0]       crc_lo_r,    crc_lo_nxt;
  logic [31:0]      cap_r  [3];
  logic [31:0]      held_r [3];
  logic [31:0]      held_nxt [3];
  logic             online_r,    online_nxt;
  logic             out_valid_r;
  logic [OUT_W-1:0] out_data_r,  out_data_nxt;

  logic             s1_res;
  logic             out_free;
  logic             s1_fire;
  logic [15:0]      crc_step;
  logic [2:0]       cause;
  logic             cap_en;
  logic [CNT_W-1:0] cap_off;
  logic [1:0]       cap_idx;

  mbsrc_crc_step u_crc (
    .crc_in  (crc_r),
    .data_in (s1_byte_r),
    .crc_out (crc_step)
  );

  // Handshake: stage one moves on unless its result finds the output full
  assign s1_res     = s1_op_r || (byte_cnt_r == POS_LAST);
  assign out_free   = !out_valid_r || out_tready;
  assign s1_fire    = s1_valid_r && (!s1_res || out_free);
  assign in_tready  = !s1_valid_r || s1_fire;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Word capture position
  assign cap_en  = !s1_op_r && (byte_cnt_r >= POS_WORD_LO) && (byte_cnt_r <= POS_WORD_HI);
  assign cap_off = byte_cnt_r - POS_WORD_LO;
  assign cap_idx = cap_off[3:2];

  // Frame state update for the item in stage one
  always_comb begin
    byte_cnt_nxt = byte_cnt_r;
    crc_nxt      = crc_r;
    hdr_nxt      = hdr_r;
    crc_lo_nxt   = crc_lo_r;
    online_nxt   = online_r;
    cause        = CAUSE_OK;
    for (int k = 0; k < 3; k++) begin
      held_nxt[k] = held_r[k];
    end
    if (s1_op_r) begin
      cause        = CAUSE_TIMEOUT;
      online_nxt   = 1'b0;
      byte_cnt_nxt = '0;
      crc_nxt      = CRC_INIT;
      hdr_nxt      = '0;
    end else if (byte_cnt_r < POS_CRC_LO) begin
      if (byte_cnt_r == CNT_W'(0) && s1_byte_r == slave_addr_r) begin
        hdr_nxt[0] = 1'b1;
      end
      if (byte_cnt_r == CNT_W'(1) && s1_byte_r == FUNC_READ_HOLDING) begin
        hdr_nxt[1] = 1'b1;
      end
      crc_nxt      = crc_step;
      byte_cnt_nxt = byte_cnt_r + CNT_W'(1);
    end else if (byte_cnt_r == POS_CRC_LO) begin
      crc_lo_nxt   = s1_byte_r;
      byte_cnt_nxt = byte_cnt_r + CNT_W'(1);
    end else begin
      // Last byte: address first, then function, then CRC
      priority if (!hdr_r[0]) begin
        cause = CAUSE_ADDRESS;
      end else if (!hdr_r[1]) begin
        cause = CAUSE_FUNCTION;
      end else if ({s1_byte_r, crc_lo_r} != crc_r) begin
        cause = CAUSE_CRC;
      end else begin
        cause = CAUSE_OK;
      end
      if (cause == CAUSE_OK) begin
        for (int k = 0; k < 3; k++) begin
          held_nxt[k] = cap_r[k];
        end
        online_nxt = 1'b1;
      end else begin
        online_nxt = 1'b0;
      end
      byte_cnt_nxt = '0;
      crc_nxt      = CRC_INIT;
      hdr_nxt      = '0;
    end
    out_data_nxt = {(OUT_W - RES_BITS)'(0), held_nxt[2], held_nxt[1], held_nxt[0],
                    online_nxt, cause, (cause == CAUSE_OK)};
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      slave_addr_r <= 8'd1;
      byte_cnt_r   <= '0;
      crc_r        <= CRC_INIT;
      hdr_r        <= '0;
      crc_lo_r     <= '0;
      online_r     <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        held_r[k] <= '0;
      end
    end else begin
      if (cfg_we) begin
        slave_addr_r <= cfg_wdata;
      end
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (s1_fire) begin
        byte_cnt_r <= byte_cnt_nxt;
        crc_r      <= crc_nxt;
        hdr_r      <= hdr_nxt;
        crc_lo_r   <= crc_lo_nxt;
        online_r   <= online_nxt;
        for (int k = 0; k < 3; k++) begin
          held_r[k] <= held_nxt[k];
        end
      end
      // Hold a result until taken; load a new one when stage one emits
      if (s1_fire && s1_res) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_tready) begin
      s1_op_r   <= in_tuser;
      s1_byte_r <= in_tdata;
    end
    if (s1_fire && cap_en) begin
      cap_r[cap_idx] <= {cap_r[cap_idx][23:0], s1_byte_r};
    end
    if (s1_fire && s1_res) begin
      out_data_r <= out_data_nxt;
    end
  end

  // Counter never passes the last frame position
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    byte_cnt_r <= POS_LAST)
    else $error("byte counter out of range");

  // Timeout restarts the frame
  a_timeout_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_op_r) |=> (byte_cnt_r == '0 && crc_r == CRC_INIT && hdr_r == '0))
    else $error("timeout did not restart frame");

  // Shown online flag matches the live flag while a result waits
  a_online_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r[4] == online_r))
    else $error("result online flag differs from state");

  // frame_ok agrees with cause and implies online
  a_ok_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_data_r[0] == (out_data_r[3:1] == CAUSE_OK))
                     && (!out_data_r[0] || out_data_r[4])))
    else $error("frame_ok inconsistent with cause");

  // A result lost under stall would show as a fire against a full output
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_res) |-> out_free)
    else $error("result overwrote a waiting one");

endmodule : modbus_status_reply_checker
`default_nettype wire

@@ tb/sv/tb.sv @@
// Self-checking testbench for the Modbus RTU read-holding reply checker.
`timescale 1ns / 100ps

module tb;
  import mbsrc_pkg::*;

  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_TIMEOUT = 1'b1;
  localparam int   PHASE_ITEMS = 300;
  localparam int   NUM_PHASES  = 6;

  typedef struct packed {
    logic       op;
    logic [7:0] data;
  } line_item_t;

  typedef struct packed {
    logic        ok;
    logic [2:0]  cause;
    logic        online;
    logic [31:0] status;
    logic [31:0] position;
    logic [31:0] speed;
  } reply_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [7:0]       cfg_wdata;
  logic             in_tvalid;
  logic             in_tready;
  logic [7:0]       in_tdata;   // [7:0] byte_in
  logic             in_tuser;   // [0] op
  logic             out_tvalid;
  logic             out_tready;
  // [0] frame_ok, [3:1] fail_cause, [4] link_online, [36:5] device_status,
  // [68:37] position_mm, [100:69] speed_mm_s, upper bits zero
  logic [OUT_W-1:0] out_tdata;

  modbus_status_reply_checker dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Stimulus and expectation stores
  line_item_t line_bytes[$];
  reply_t     expected_replies[$];

  int n_sent;
  int n_taken;
  int n_errors;
  int n_replies;
  int n_good;
  int n_timeouts;
  int n_addr_writes;
  int tx_idle_pct;
  int rx_idle_pct;
  logic in_acc;
  logic [7:0] gen_addr;

  // Predictor state
  logic [7:0]  exp_addr;
  logic [4:0]  frm_count;
  logic [15:0] frm_crc;
  logic [1:0]  hdr_ok;
  logic [31:0] frm_words [3];
  logic [7:0]  crc_lo;
  logic [31:0] held [3];
  logic        online;

  // Clock: 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++)
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    return r;
  endfunction

  // Restart the frame tracker after a frame end or a timeout
  task automatic restart_tracker();
    frm_count = '0;
    frm_crc   = CRC_INIT;
    hdr_ok    = '0;
  endtask

  task automatic post_reply(input logic [2:0] cause);
    reply_t r;
    r.ok       = (cause == CAUSE_OK);
    r.cause    = cause;
    r.online   = online;
    r.status   = held[0];
    r.position = held[1];
    r.speed    = held[2];
    expected_replies.push_back(r);
  endtask

  // Advance the predicted frame state by one accepted item
  task automatic track_reply_byte(input logic op, input logic [7:0] b);
    int          pos;
    int          w;
    logic [15:0] got;
    logic [2:0]  cause;
    if (op == OP_TIMEOUT) begin
      online = 1'b0;
      restart_tracker();
      post_reply(CAUSE_TIMEOUT);
    end else begin
      pos = int'(frm_count);
      if (pos == 0 && b == exp_addr) hdr_ok[0] = 1'b1;
      if (pos == 1 && b == FUNC_READ_HOLDING) hdr_ok[1] = 1'b1;
      if (pos >= 3 && pos <= 14) begin
        w = (pos - 3) >> 2;
        frm_words[w] = {frm_words[w][23:0], b};
      end
      if (pos < FRAME_BYTES - 2) begin
        frm_crc   = crc16_byte(frm_crc, b);
        frm_count = frm_count + 5'd1;
      end else if (pos == FRAME_BYTES - 2) begin
        crc_lo    = b;
        frm_count = frm_count + 5'd1;
      end else begin
        got = {b, crc_lo};
        if (!hdr_ok[0])
          cause = CAUSE_ADDRESS;
        else if (!hdr_ok[1])
          cause = CAUSE_FUNCTION;
        else if (got != frm_crc)
          cause = CAUSE_CRC;
        else
          cause = CAUSE_OK;
        if (cause == CAUSE_OK) begin
          for (int i = 0; i < 3; i++) held[i] = frm_words[i];
          online = 1'b1;
        end else begin
          online = 1'b0;
        end
        restart_tracker();
        post_reply(cause);
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      n_errors++;
    end
  endtask

  // Monitor: check replies, track config writes and accepted items
  always @(posedge clk) begin
    reply_t exp_r;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_replies.size() == 0) begin
          $error("reply with none expected: tdata 0x%0h", out_tdata);
          n_errors++;
        end else begin
          exp_r = expected_replies.pop_front();
          check_field("frame_ok", 32'(exp_r.ok), 32'(out_tdata[0]));
          check_field("fail_cause", 32'(exp_r.cause), 32'(out_tdata[3:1]));
          check_field("link_online", 32'(exp_r.online), 32'(out_tdata[4]));
          check_field("device_status", exp_r.status, out_tdata[36:5]);
          check_field("position_mm", exp_r.position, out_tdata[68:37]);
          check_field("speed_mm_s", exp_r.speed, out_tdata[100:69]);
          n_replies++;
          if (exp_r.cause == CAUSE_OK) n_good++;
          if (exp_r.cause == CAUSE_TIMEOUT) n_timeouts++;
        end
      end
      if (cfg_we) exp_addr = cfg_wdata;
      if (in_tvalid && in_tready) begin
        track_reply_byte(in_tuser, in_tdata);
        n_taken++;
      end
    end
    in_acc <= rst_n && in_tvalid && in_tready;
  end

  // Driver: present the next item once the current one is taken; toggle ready
  always @(negedge clk) begin
    line_item_t nxt;
    if (!in_tvalid || in_acc) begin
      if (line_bytes.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        nxt = line_bytes.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= nxt.op;
        in_tdata  <= nxt.data;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  task automatic push_item(input logic op, input logic [7:0] b);
    line_item_t it;
    it.op   = op;
    it.data = b;
    line_bytes.push_back(it);
    n_sent++;
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Build one fixed-length reply frame, optionally with a broken CRC
  task automatic add_reply_frame(input logic [7:0] a, input logic [7:0] fn,
                                 input logic [31:0] w0, input logic [31:0] w1,
                                 input logic [31:0] w2, input bit bad_crc);
    logic [7:0]  fb [FRAME_BYTES];
    logic [95:0] words;
    logic [15:0] c;
    words = {w0, w1, w2};
    fb[0] = a;
    fb[1] = fn;
    fb[2] = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'd12;
    for (int i = 3; i <= 14; i++) fb[i] = words[95 - 8 * (i - 3) -: 8];
    for (int i = 15; i <= FRAME_BYTES - 3; i++) fb[i] = 8'($urandom);
    c = CRC_INIT;
    for (int i = 0; i <= FRAME_BYTES - 3; i++) c = crc16_byte(c, fb[i]);
    if (bad_crc) c = c ^ 16'($urandom_range(1, 16'hFFFF));
    fb[FRAME_BYTES - 2] = c[7:0];
    fb[FRAME_BYTES - 1] = c[15:8];
    for (int i = 0; i < FRAME_BYTES; i++) push_item(OP_BYTE, fb[i]);
  endtask

  // Hold until every item is taken and every reply has arrived
  task automatic wait_drained();
    while (n_taken != n_sent || expected_replies.size() != 0) @(negedge clk);
  endtask

  task automatic write_slave_address(input logic [7:0] v);
    wait_drained();
    repeat (4) @(negedge clk);
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
    gen_addr = v;
    n_addr_writes++;
  endtask

  task automatic add_random_traffic();
    int          kind;
    logic [7:0]  a;
    logic [7:0]  fn;
    bit          bad;
    int          n;
    kind = $urandom_range(0, 99);
    a    = gen_addr;
    fn   = FUNC_READ_HOLDING;
    bad  = 1'b0;
    if (kind < 55) begin
      add_reply_frame(a, fn, rand_word(), rand_word(), rand_word(), 1'b0);
    end else if (kind < 84) begin
      // Faulty frame: address, function, CRC, or a mix of them
      if (kind < 63 || (kind >= 79 && $urandom_range(0, 1)))
        a = gen_addr ^ 8'($urandom_range(1, 255));
      if ((kind >= 63 && kind < 71) || (kind >= 79 && $urandom_range(0, 1))) begin
        fn = 8'($urandom);
        if (fn == FUNC_READ_HOLDING) fn = fn ^ 8'h80;
      end
      if ((kind >= 71 && kind < 79) || (kind >= 79 && $urandom_range(0, 1)))
        bad = 1'b1;
      add_reply_frame(a, fn, rand_word(), rand_word(), rand_word(), bad);
    end else if (kind < 92) begin
      // Truncated frame cut off by the reply window
      n = $urandom_range(0, FRAME_BYTES - 1);
      if (n > 0) push_item(OP_BYTE, gen_addr);
      for (int i = 1; i < n; i++) push_item(OP_BYTE, 8'($urandom));
      push_item(OP_TIMEOUT, 8'($urandom));
    end else begin
      // Line noise, then a timeout to resynchronise
      n = $urandom_range(1, 30);
      for (int i = 0; i < n; i++) push_item(OP_BYTE, 8'($urandom));
      push_item(OP_TIMEOUT, 8'($urandom));
    end
  endtask

  // Run limit
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // Sequencer: reset, directed items, then random phases
  initial begin
    int start;
    clk        = 1'b0;
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = 1'b0;
    out_tready = 1'b0;
    in_acc     = 1'b0;
    n_sent = 0; n_taken = 0; n_errors = 0;
    n_replies = 0; n_good = 0; n_timeouts = 0; n_addr_writes = 0;
    tx_idle_pct = 27;
    rx_idle_pct = 86;
    gen_addr = 8'd1;
    exp_addr = 8'd1;
    crc_lo   = '0;
    online   = 1'b0;
    for (int i = 0; i < 3; i++) begin
      held[i]      = '0;
      frm_words[i] = '0;
    end
    restart_tracker();

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: timeout before any byte (junk data), all-ones good frame,
    // then a short frame of zero bytes cut off by a timeout
    push_item(OP_TIMEOUT, 8'hFF);
    add_reply_frame(gen_addr, FUNC_READ_HOLDING, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    32'hFFFF_FFFF, 1'b0);
    push_item(OP_BYTE, 8'h00);
    push_item(OP_BYTE, 8'h00);
    push_item(OP_BYTE, 8'h00);
    push_item(OP_TIMEOUT, 8'h00);

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p % 3)
        0:       write_slave_address(8'hFF);
        1:       write_slave_address(8'h00);
        default: write_slave_address(8'($urandom));
      endcase
      case (p / 2)
        0: begin tx_idle_pct = 27; rx_idle_pct = 86; end
        1: begin tx_idle_pct = 86; rx_idle_pct = 27; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      start = n_sent;
      while (n_sent - start < PHASE_ITEMS) add_random_traffic();
    end

    wait_drained();
    repeat (8) @(negedge clk);

    $display("%0d items sent over %0d address settings and three idle profiles",
             n_sent, n_addr_writes + 1);
    $display("%0d replies checked: %0d good frames, %0d timeouts, rest faults",
             n_replies, n_good, n_timeouts);
    if (n_errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
